// ----- hw/rtl/tmts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmts_pkg
// Shared opcodes and constants for the trigram Markov train/sample unit.
// ----------------------------------------------------------------------------
package tmts_pkg;

    localparam int SYM_W  = 5;
    localparam int RND_W  = 31;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TRAIN  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage
`default_nettype wire

// ----- hw/rtl/trigram_markov_train_sample_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trigram_markov_train_sample_unit
// Second-order Markov count table with training and weighted sampling.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction: op, symbol, context and random
//   value. Start and train items give no result; a sample item gives exactly
//   one result on m_axis (picked symbol, row-empty flag).
//   Counts live in one synchronous memory (rows x SYMBOLS) and row totals in a
//   second one, both with a registered read port.
//   Reset: after aresetn the block runs a clearing pass over the row-total
//   memory and count memory, one entry per cycle, over all ROWS*SYMBOLS count
//   entries (20439 for the defaults); no item is accepted meanwhile.
//   Steps: start, ignored items and the first two symbols of a word end on
//   acceptance; a counted update is a read, wait and write (one for a later
//   symbol, three for the third symbol of a word). A sample reads the row
//   total, takes the remainder of the random value (one bit per cycle), then
//   walks the counts with a read, wait and add each; an empty row or a bad context skips both.
//   One item is in work at a time. A finished result waits in the output
//   register; while m_axis is stalled a new item can be taken and processed
//   up to the point it needs to present its own result.
// ----------------------------------------------------------------------------
module trigram_markov_train_sample_unit #(
    parameter int SYMBOLS    = 27,
    parameter int COUNT_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: op[1:0], symbol[6:2], context_length[8:7], context_first[13:9],
    //        context_second[18:14], random_value[49:19], zeros[55:50]
    input  wire  [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: picked_symbol[4:0], zeros[7:5]
    output logic [7:0]  m_axis_tdata,
    // tuser: row_empty
    output logic        m_axis_tuser
);
    import tmts_pkg::*;

    localparam int ROWS     = 1 + SYMBOLS + SYMBOLS * SYMBOLS;
    localparam int ENTRIES  = ROWS * SYMBOLS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ADR_W    = $clog2(ENTRIES);
    localparam int SI_W     = $clog2(SYMBOLS);
    localparam int TOT_W    = COUNT_BITS + 5;
    localparam int REM_W    = (TOT_W > RND_W) ? TOT_W : RND_W;
    localparam int BITC_W   = $clog2(RND_W + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [TOT_W-1:0]      TMAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BUMP_RD, S_BUMP_WAIT, S_BUMP_WR,
        S_SMP_RD, S_SMP_WAIT, S_MOD, S_WALK_RD, S_WALK_WAIT, S_WALK, S_OUT
    } state_t;

    // memories
    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
    logic [TOT_W-1:0]      tot_mem [ROWS];
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [TOT_W-1:0]      tot_rd;
    logic                  cnt_we, tot_we;
    logic [ADR_W-1:0]      cnt_wa, cnt_ra;
    logic [ROW_W-1:0]      tot_wa, tot_ra;
    logic [COUNT_BITS-1:0] cnt_wd;
    logic [TOT_W-1:0]      tot_wd;

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
    end
    always_ff @(posedge aclk) begin
        if (tot_we) tot_mem[tot_wa] <= tot_wd;
        tot_rd <= tot_mem[tot_ra];
    end

    state_t                state_reg;
    logic [ADR_W-1:0]      clr_reg;
    logic [1:0]            wpos_reg;
    logic [SYM_W-1:0]      old_reg, new_reg;
    // pending bumps: up to three (row 0, row 1+a, pair row)
    logic [ROW_W-1:0]      brow_reg [3];
    logic [SI_W-1:0]       bsym_reg [3];
    logic [1:0]            bi_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [ADR_W-1:0]      base_reg;
    logic [TOT_W-1:0]      total_reg;
    logic [RND_W-1:0]      rnd_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [BITC_W-1:0]     bitc_reg;
    logic [SI_W-1:0]       idx_reg;
    logic [TOT_W-1:0]      acc_reg;
    logic [SYM_W-1:0]      pick_reg;
    logic                  empty_reg;

    // input fields
    logic [1:0]       in_op, in_len;
    logic [SYM_W-1:0] in_sym, in_a, in_b;
    logic [RND_W-1:0] in_rnd;
    assign in_op  = s_axis_tdata[1:0];
    assign in_sym = s_axis_tdata[6:2];
    assign in_len = s_axis_tdata[8:7];
    assign in_a   = s_axis_tdata[13:9];
    assign in_b   = s_axis_tdata[18:14];
    assign in_rnd = s_axis_tdata[49:19];

    assign s_axis_tready = (state_reg == S_IDLE);
    wire s_acc = s_axis_tvalid && s_axis_tready;

    function automatic logic [ROW_W-1:0] pair_row(input logic [SYM_W-1:0] a,
                                                   input logic [SYM_W-1:0] b);
        logic [ROW_W+SYM_W:0] t;
        t = (ROW_W+SYM_W+1)'(1 + SYMBOLS) + (ROW_W+SYM_W+1)'(a) * (ROW_W+SYM_W+1)'(SYMBOLS)
            + (ROW_W+SYM_W+1)'(b);
        return t[ROW_W-1:0];
    endfunction

    wire sym_ok = ({1'b0, in_sym} < (SYM_W+1)'(SYMBOLS));
    wire a_ok   = ({1'b0, in_a} < (SYM_W+1)'(SYMBOLS));
    wire b_ok   = ({1'b0, in_b} < (SYM_W+1)'(SYMBOLS));

    // memory addressing
    logic [ADR_W+SYM_W:0] bprod;
    assign bprod = (ADR_W+SYM_W+1)'(brow_reg[bi_reg]) * (ADR_W+SYM_W+1)'(SYMBOLS)
                   + (ADR_W+SYM_W+1)'(bsym_reg[bi_reg]);
    logic [ADR_W+SYM_W:0] rprod;
    assign rprod = (ADR_W+SYM_W+1)'(row_reg) * (ADR_W+SYM_W+1)'(SYMBOLS);

    // restoring remainder step
    logic [REM_W:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, rnd_reg[RND_W-1]};
    assign rem_sub = rem_sh - (REM_W+1)'(total_reg);
    wire [TOT_W-1:0] acc_new = acc_reg + TOT_W'(cnt_rd);

    always_comb begin
        cnt_we = 1'b0; tot_we = 1'b0;
        cnt_wa = clr_reg; tot_wa = clr_reg[ROW_W-1:0];
        cnt_wd = '0; tot_wd = '0;
        cnt_ra = bprod[ADR_W-1:0]; tot_ra = brow_reg[bi_reg];
        unique case (state_reg) inside
            S_CLEAR: begin
                cnt_we = 1'b1;
                tot_we = (clr_reg < ADR_W'(ROWS));
            end
            S_BUMP_WR: begin
                cnt_wa = bprod[ADR_W-1:0]; tot_wa = brow_reg[bi_reg];
                cnt_wd = cnt_rd + 1'b1; tot_wd = tot_rd + 1'b1;
                cnt_we = (cnt_rd != CMAX) && (tot_rd != TMAX);
                tot_we = cnt_we;
            end
            S_SMP_RD: tot_ra = row_reg;
            // hold the walk address through the wait so the read data stays put
            S_WALK_RD, S_WALK_WAIT: cnt_ra = base_reg + ADR_W'(idx_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            wpos_reg      <= '0;
            old_reg       <= '0;
            new_reg       <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && state_reg != S_OUT)
                m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADR_W'(ENTRIES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_acc) begin
                    case (in_op)
                        OP_START: wpos_reg <= '0;
                        OP_TRAIN: if (sym_ok) begin
                            case (wpos_reg)
                                2'd0: begin old_reg <= in_sym; wpos_reg <= 2'd1; end
                                2'd1: begin new_reg <= in_sym; wpos_reg <= 2'd2; end
                                default: begin
                                    brow_reg[0] <= pair_row(old_reg, new_reg);
                                    bsym_reg[0] <= SI_W'(in_sym);
                                    brow_reg[1] <= '0;
                                    bsym_reg[1] <= SI_W'(old_reg);
                                    brow_reg[2] <= ROW_W'(old_reg) + 1'b1;
                                    bsym_reg[2] <= SI_W'(new_reg);
                                    bi_reg <= (wpos_reg == 2'd2) ? 2'd2 : 2'd0;
                                    old_reg <= new_reg;
                                    new_reg <= in_sym;
                                    wpos_reg <= 2'd3;
                                    state_reg <= S_BUMP_RD;
                                end
                            endcase
                        end
                        OP_SAMPLE: begin
                            rnd_reg <= in_rnd;
                            if (in_len == 2'd0) begin
                                row_reg <= '0; state_reg <= S_SMP_RD;
                            end else if (in_len == 2'd1 && a_ok) begin
                                row_reg <= ROW_W'(in_a) + 1'b1; state_reg <= S_SMP_RD;
                            end else if (in_len == 2'd2 && a_ok && b_ok) begin
                                row_reg <= pair_row(in_a, in_b); state_reg <= S_SMP_RD;
                            end else begin
                                pick_reg <= '0; empty_reg <= 1'b1; state_reg <= S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
                S_BUMP_RD:   state_reg <= S_BUMP_WAIT;
                S_BUMP_WAIT: state_reg <= S_BUMP_WR;
                S_BUMP_WR: begin
                    // order: row 1+a, row 0, then pair row
                    if (bi_reg == 2'd0) state_reg <= S_IDLE;
                    else begin
                        bi_reg <= (bi_reg == 2'd2) ? 2'd1 : 2'd0;
                        state_reg <= S_BUMP_RD;
                    end
                end
                S_SMP_RD: begin
                    base_reg  <= rprod[ADR_W-1:0];
                    state_reg <= S_SMP_WAIT;
                end
                S_SMP_WAIT: begin
                    total_reg <= tot_rd;
                    rem_reg   <= '0;
                    bitc_reg  <= '0;
                    if (tot_rd == '0) begin
                        pick_reg <= '0; empty_reg <= 1'b1; state_reg <= S_OUT;
                    end else state_reg <= S_MOD;
                end
                S_MOD: begin
                    rem_reg  <= rem_sub[REM_W] ? rem_sh[REM_W-1:0] : rem_sub[REM_W-1:0];
                    rnd_reg  <= {rnd_reg[RND_W-2:0], 1'b0};
                    bitc_reg <= bitc_reg + 1'b1;
                    if (bitc_reg == BITC_W'(RND_W - 1)) begin
                        idx_reg <= '0; acc_reg <= '0; state_reg <= S_WALK_RD;
                    end
                end
                S_WALK_RD:   state_reg <= S_WALK_WAIT;
                S_WALK_WAIT: state_reg <= S_WALK;
                S_WALK: begin
                    acc_reg <= acc_new;
                    if ((REM_W+1)'(acc_new) > (REM_W+1)'(rem_reg)
                        || idx_reg == SI_W'(SYMBOLS - 1)) begin
                        pick_reg <= SYM_W'(idx_reg); empty_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1; state_reg <= S_WALK_RD;
                    end
                end
                S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata  <= {3'b000, pick_reg};
                    m_axis_tuser  <= empty_reg;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trigram_markov_train_sample_unit: trains words and
// samples contexts over the stream ports, predicts every pick from a local
// copy of the count table and compares each result as it is accepted.
// ----------------------------------------------------------------------------
module testbench;
    import tmts_pkg::*;

    localparam int NSYM      = 27;
    localparam int NROWS     = 1 + NSYM + NSYM * NSYM;
    localparam int CNT_W     = 16;
    localparam int TOT_W     = CNT_W + 5;
    localparam int IDLE_LIM  = 100000;

    typedef struct packed {
        logic [4:0] picked;
        logic       empty;
    } pick_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;

    // Local model state
    logic [CNT_W-1:0] count_mem [NROWS*NSYM];
    logic [TOT_W-1:0] total_mem [NROWS];
    logic [1:0]       word_pos;
    logic [4:0]       prev2_sym;
    logic [4:0]       prev1_sym;

    pick_t pick_q[$];
    int    fail_cnt;
    bit    src_idle;
    bit    sink_idle;
    bit    hold_req;
    int    hold_cnt;
    int    burst_cnt;
    int    quiet_cnt;

    trigram_markov_train_sample_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Count one symbol in one row unless count or total is saturated
    function automatic void count_up(int row, int sym);
        int k;
        k = row * NSYM + sym;
        if (count_mem[k] == '1 || total_mem[row] == '1) return;
        count_mem[k]   = count_mem[k] + 1'b1;
        total_mem[row] = total_mem[row] + 1'b1;
    endfunction

    function automatic void learn_symbol(logic [4:0] sym);
        if (sym >= NSYM) return;
        case (word_pos)
            2'd0: begin
                prev2_sym = sym;
                word_pos  = 2'd1;
            end
            2'd1: begin
                prev1_sym = sym;
                word_pos  = 2'd2;
            end
            default: begin
                if (word_pos == 2'd2) begin
                    count_up(0, prev2_sym);
                    count_up(1 + prev2_sym, prev1_sym);
                end
                count_up(1 + NSYM + prev2_sym * NSYM + prev1_sym, sym);
                prev2_sym = prev1_sym;
                prev1_sym = sym;
                word_pos  = 2'd3;
            end
        endcase
    endfunction

    // Weighted pick over one context row
    function automatic pick_t pick_next(logic [1:0] len, logic [4:0] a, logic [4:0] b,
                                        logic [30:0] rnd);
        pick_t      res;
        int         row;
        logic [TOT_W-1:0] rem;
        logic [TOT_W-1:0] acc;
        int         i;
        res.picked = '0;
        res.empty  = 1'b1;
        if (len == 2'd0) row = 0;
        else if (len == 2'd1) begin
            if (a >= NSYM) return res;
            row = 1 + a;
        end else if (len == 2'd2) begin
            if (a >= NSYM || b >= NSYM) return res;
            row = 1 + NSYM + a * NSYM + b;
        end else return res;
        if (total_mem[row] == 0) return res;
        rem = TOT_W'(rnd % total_mem[row]);
        acc = '0;
        for (i = 0; i < NSYM; i++) begin
            acc = acc + count_mem[row * NSYM + i];
            if (acc > rem) break;
        end
        if (i >= NSYM) i = NSYM - 1;
        res.picked = 5'(i);
        res.empty  = 1'b0;
        return res;
    endfunction

    // Offer one item, wait for its transaction, then update the model
    task automatic send_item(op_t op, logic [4:0] sym, logic [1:0] len, logic [4:0] a,
                             logic [4:0] b, logic [30:0] rnd);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, rnd, b, a, len, sym, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        case (op)
            OP_START:  word_pos = 2'd0;
            OP_TRAIN:  learn_symbol(sym);
            OP_SAMPLE: pick_q.push_back(pick_next(len, a, b, rnd));
            default: ;
        endcase
    endtask

    task automatic train_word(int n, int alpha);
        send_item(OP_START, 5'($urandom), 2'($urandom), 5'($urandom), 5'($urandom),
                  31'($urandom));
        repeat (n) send_item(OP_TRAIN, 5'($urandom_range(0, alpha - 1)), 2'($urandom),
                             5'($urandom), 5'($urandom), 31'($urandom));
    endtask

    task automatic sample_ctx(int alpha);
        send_item(OP_SAMPLE, 5'($urandom), 2'($urandom_range(0, 2)),
                  5'($urandom_range(0, alpha - 1)), 5'($urandom_range(0, alpha - 1)),
                  31'($urandom));
    endtask

    task automatic test_directed();
        // empty rows, bad contexts, unknown op
        send_item(OP_SAMPLE, 5'd0, 2'd0, 5'd0, 5'd0, 31'h7FFF_FFFF);
        send_item(OP_SAMPLE, 5'd31, 2'd1, 5'd26, 5'd0, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd2, 5'd26, 5'd26, 31'd5);
        send_item(OP_SAMPLE, 5'd0, 2'd3, 5'd0, 5'd0, 31'd1);
        send_item(OP_NONE, 5'd3, 2'd0, 5'd0, 5'd0, 31'd0);
        // short words leave no trace
        send_item(OP_START, 5'd0, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_TRAIN, 5'd4, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_START, 5'd0, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_TRAIN, 5'd4, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_TRAIN, 5'd31, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_TRAIN, 5'd26, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd0, 5'd0, 5'd0, 31'd0);
        // third symbol counts the word; sampling keeps word state
        send_item(OP_TRAIN, 5'd0, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd2, 5'd4, 5'd26, 31'h7FFF_FFFF);
        send_item(OP_TRAIN, 5'd26, 2'd0, 5'd0, 5'd0, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd0, 5'd0, 5'd0, 31'h7FFF_FFFF);
        send_item(OP_SAMPLE, 5'd0, 2'd1, 5'd4, 5'd0, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd2, 5'd26, 5'd0, 31'd1);
        send_item(OP_SAMPLE, 5'd0, 2'd1, 5'd31, 5'd0, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd2, 5'd4, 5'd27, 31'd0);
        send_item(OP_SAMPLE, 5'd0, 2'd2, 5'd27, 5'd4, 31'd0);
    endtask

    // Receiver holds off while samples keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (30) sample_ctx(4);
    endtask

    task automatic test_random(int n_items);
        int sent;
        int len;
        int alpha;
        sent = 0;
        while (sent < n_items) begin
            alpha = ($urandom_range(0, 3) == 0) ? NSYM : 4;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 7);
                    train_word(len, alpha);
                    sent += len + 1;
                end
                4, 5, 6, 7: begin
                    sample_ctx(alpha);
                    sent++;
                end
                default: begin
                    send_item(op_t'($urandom), 5'($urandom), 2'($urandom),
                              5'($urandom), 5'($urandom), 31'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    // Receiver: random stall bursts, one long hold on request, result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pick_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_cnt++;
                end else begin
                    if (m_axis_tdata[4:0] !== pick_q[0].picked) begin
                        $error("picked_symbol expected %0d actual %0d",
                               pick_q[0].picked, m_axis_tdata[4:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tuser !== pick_q[0].empty) begin
                        $error("row_empty expected %0d actual %0d",
                               pick_q[0].empty, m_axis_tuser);
                        fail_cnt++;
                    end
                    void'(pick_q.pop_front());
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (burst_cnt > 0) begin
                burst_cnt--;
                m_axis_tready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                burst_cnt = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= IDLE_LIM) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        fail_cnt      = 0;
        quiet_cnt     = 0;
        hold_cnt      = 0;
        burst_cnt     = 0;
        hold_req      = 1'b0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        word_pos      = '0;
        prev2_sym     = '0;
        prev1_sym     = '0;
        foreach (count_mem[i]) count_mem[i] = '0;
        foreach (total_mem[i]) total_mem[i] = '0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(700);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random(100);

        s_axis_tvalid <= 1'b0;
        while (pick_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (pick_q.size() != 0) begin
            $error("expectations left over: %0d", pick_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
